>>> rtl/core/bsa_pkg.sv
// Shared types, codes and helpers for the bitmap slot allocator.
// Used by bitmap_slot_allocator_top and bsa_checker; no dependencies.
package bsa_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int IDX_W     = 10;
    localparam int SIZE_W    = 16;
    localparam int RND_W     = 17;
    localparam int OFS_W     = 26;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RETURN  = 2'd1,
        OP_RECLAIM = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_DONE    = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        REG_SLOT_COUNT = 1'b0,
        REG_SLOT_SIZE  = 1'b1
    } t_reg;

    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] b;
        b = BIT_W'(WORD_BITS - 1);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

    // Freshly rebuilt word: bits of slots below n set.
    function automatic logic [WORD_BITS-1:0] init_word(input logic [7:0] w,
                                                       input logic [IDX_W-1:0] n);
        logic [13:0]      base;
        logic [13:0]      nn;
        logic [13:0]      diff;
        logic [WORD_BITS-1:0] v;
        base = {w, 6'd0} >> 1;
        nn   = 14'(n);
        diff = nn - base;
        if (nn >= base + 14'(WORD_BITS)) begin
            v = '1;
        end else if (nn > base) begin
            v = ~({WORD_BITS{1'b1}} << diff[BIT_W-1:0]);
        end else begin
            v = '0;
        end
        return v;
    endfunction

endpackage

>>> rtl/core/bsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bitmap_slot_allocator_top.sv
// A request is captured in the stage-1 registers when accepted; its result is registered
// in the output register once that register is free.
// No new request is accepted until the current one completes: the request's bitmap word is
// read from the map RAM in the accept cycle and written back when the request completes.
// Reset (synchronous, active low) empties the spare and marks every word as
// rebuilt from slot_count through per-word valid bits; no clearing pass.
module bitmap_slot_allocator_top
    import bsa_pkg::*;
#(
    parameter int MAP_WORDS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_op,
    input  logic [IDX_W-1:0]      i_slot_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [IDX_W-1:0]      o_granted_index,
    output logic [OFS_W-1:0]      o_byte_offset,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    localparam int WA_W = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
    localparam int CAP  = MAP_WORDS * WORD_BITS;

    logic [IDX_W-1:0]     r_slot_count;
    logic [SIZE_W-1:0]    r_slot_size;
    logic [IDX_W-1:0]     r_fill_n;
    logic [MAP_WORDS-1:0] r_wvalid;
    logic [MAP_WORDS-1:0] r_nz;
    logic                 r_spare_valid;
    logic [IDX_W-1:0]     r_spare_slot;

    logic                 r_s1_valid;
    logic [1:0]           r_s1_op;
    logic [IDX_W-1:0]     r_s1_idx;
    logic [WA_W-1:0]      r_s1_addr;
    logic                 r_s1_inrange;
    logic                 r_s1_hit;

    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic [IDX_W-1:0]     r_gidx;
    logic [OFS_W-1:0]     r_ofs;

    logic                 accept;
    logic                 complete;
    logic                 cfg_we;
    logic [WA_W-1:0]      first_w;
    logic                 any_nz;
    logic [BIT_W-1:0]     ret_word;
    logic                 ret_inrange;
    logic [WA_W-1:0]      rd_addr;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] cur;
    logic [BIT_W-1:0]     low_b;
    logic                 we;
    logic [WORD_BITS-1:0] wdata;
    logic                 reclaim;
    logic [IDX_W-1:0]     n_fill_n;
    logic                 n_spare_valid;
    logic [IDX_W-1:0]     n_spare_slot;
    t_status              n_status;
    logic [IDX_W-1:0]     n_gidx;
    logic                 n_grant;
    logic [RND_W-1:0]     rounded;
    logic [26:0]          prod;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_s1_valid;
    assign complete   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign cfg_we     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    always_comb begin
        unique case (t_reg'(paddr[2]))
            REG_SLOT_COUNT: prdata = DATA_W'(r_slot_count);
            REG_SLOT_SIZE:  prdata = DATA_W'(r_slot_size);
        endcase
    end

    always_comb begin
        first_w = '0;
        for (int w = MAP_WORDS - 1; w >= 0; w--) begin
            if (r_nz[w]) begin
                first_w = WA_W'(w);
            end
        end
    end

    assign any_nz      = |r_nz;
    assign ret_word    = i_slot_index[IDX_W-1:BIT_W];
    assign ret_inrange = int'(ret_word) < MAP_WORDS;
    assign rd_addr     = (t_op'(i_op) == OP_GET) ? first_w : WA_W'(ret_word);

    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_s1_addr),
        .i_wdata (wdata),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign cur   = r_wvalid[r_s1_addr] ? rdata : init_word(8'(r_s1_addr), r_fill_n);
    assign low_b = lowest_bit(cur);
    assign n_fill_n = (int'(r_slot_count) < CAP) ? r_slot_count : IDX_W'(CAP);

    always_comb begin
        we            = 1'b0;
        wdata         = cur;
        reclaim       = 1'b0;
        n_spare_valid = r_spare_valid;
        n_spare_slot  = r_spare_slot;
        n_status      = ST_DONE;
        n_gidx        = '0;
        n_grant       = 1'b0;
        case (t_op'(r_s1_op))
            OP_GET: begin
                if (r_spare_valid) begin
                    n_spare_valid = 1'b0;
                    n_gidx        = r_spare_slot;
                    n_grant       = 1'b1;
                end else if (r_s1_hit) begin
                    we      = 1'b1;
                    wdata   = cur & (cur - 1'b1);
                    n_gidx  = IDX_W'({r_s1_addr, low_b});
                    n_grant = 1'b1;
                end
                n_status = n_grant ? ST_GRANTED : ST_EMPTY;
            end
            OP_RETURN: begin
                if (!r_spare_valid) begin
                    n_spare_valid = 1'b1;
                    n_spare_slot  = r_s1_idx;
                end else if (r_s1_inrange) begin
                    we    = 1'b1;
                    wdata = cur | (WORD_BITS'(1) << r_s1_idx[BIT_W-1:0]);
                end
            end
            OP_RECLAIM: begin
                reclaim       = 1'b1;
                n_spare_valid = 1'b0;
                n_spare_slot  = '0;
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
        if (!complete) begin
            we = 1'b0;
        end
    end

    assign rounded = (RND_W'(r_slot_size) + RND_W'(3)) & ~RND_W'(3);
    assign prod    = 27'(n_gidx) * 27'(rounded);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count  <= IDX_W'(1023);
            r_slot_size   <= SIZE_W'(4);
            r_fill_n      <= (CAP > 1023) ? IDX_W'(1023) : IDX_W'(CAP);
            r_wvalid      <= '0;
            for (int w = 0; w < MAP_WORDS; w++) begin
                r_nz[w] <= ((CAP > 1023) ? 1023 : CAP) > w * WORD_BITS;
            end
            r_spare_valid <= 1'b0;
            r_spare_slot  <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (t_reg'(paddr[2]))
                    REG_SLOT_COUNT: r_slot_count <= pwdata[IDX_W-1:0];
                    REG_SLOT_SIZE:  r_slot_size  <= pwdata[SIZE_W-1:0];
                endcase
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (complete) begin
                r_s1_valid <= 1'b0;
            end
            if (complete) begin
                r_out_valid   <= 1'b1;
                r_spare_valid <= n_spare_valid;
                r_spare_slot  <= n_spare_slot;
                if (reclaim) begin
                    r_fill_n <= n_fill_n;
                    r_wvalid <= '0;
                    for (int w = 0; w < MAP_WORDS; w++) begin
                        r_nz[w] <= int'(n_fill_n) > w * WORD_BITS;
                    end
                end else if (we) begin
                    r_wvalid[r_s1_addr] <= 1'b1;
                    r_nz[r_s1_addr]     <= |wdata;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op      <= i_op;
            r_s1_idx     <= i_slot_index;
            r_s1_addr    <= rd_addr;
            r_s1_inrange <= ret_inrange;
            r_s1_hit     <= any_nz;
        end
        if (complete) begin
            r_status <= n_status;
            r_gidx   <= n_grant ? n_gidx : '0;
            r_ofs    <= n_grant ? prod[OFS_W-1:0] : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_index = r_gidx;
    assign o_byte_offset   = r_ofs;

endmodule

>>> rtl/core/bsa_checker.sv
// Port-level checks for bitmap_slot_allocator_top, attached by bind.
// Depends on bsa_pkg for status codes and field widths.
module bsa_checker
    import bsa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         o_status,
    input logic [IDX_W-1:0]   o_granted_index,
    input logic [OFS_W-1:0]   o_byte_offset,
    input logic               pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_granted_index)
            && $stable(o_byte_offset))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_GRANTED |->
            o_granted_index == '0 && o_byte_offset == '0)
        else $error("nonzero fields without a grant");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_GRANTED || o_status == ST_EMPTY
            || o_status == ST_DONE)
        else $error("undefined status code");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind bitmap_slot_allocator_top bsa_checker u_bsa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_granted_index (o_granted_index),
    .o_byte_offset   (o_byte_offset),
    .pready          (pready)
);

>>> sim/bitmap_slot_allocator_top_test.sv
// Self-checking testbench for bitmap_slot_allocator_top: directed and random get, return and
// reclaim requests under random idling and back-pressure, checked against a local pool model.
// Depends on bsa_pkg and bitmap_slot_allocator_top.
module bitmap_slot_allocator_top_test;
    import bsa_pkg::*;

    localparam int          MAP_WORDS     = 32;
    localparam int          WATCHDOG_MAX  = 5000;
    localparam int          LONG_HOLD     = 150;
    localparam int          DRAIN_SLACK   = 4;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;

    typedef struct {
        t_status          status;
        logic [IDX_W-1:0] index;
        logic [OFS_W-1:0] offset;
    } t_pool_answer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_op;
    logic [IDX_W-1:0]      i_slot_index;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_status;
    logic [IDX_W-1:0]      o_granted_index;
    logic [OFS_W-1:0]      o_byte_offset;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // pool model state
    logic [WORD_BITS-1:0]  free_words [MAP_WORDS];
    logic                  spare_held;
    logic [IDX_W-1:0]      spare_index;
    logic [IDX_W-1:0]      cfg_slot_count;
    logic [SIZE_W-1:0]     cfg_slot_size;

    t_pool_answer          pending_answers [$];
    logic [IDX_W-1:0]      held_slots [$];
    t_pool_answer          head_answer;

    int                    errors        = 0;
    int                    requests_sent = 0;
    int                    grants_seen   = 0;
    int                    empties_seen  = 0;
    int                    reg_writes    = 0;
    int                    quiet_cycles  = 0;
    int                    burst_left    = 0;
    int                    gap_max       = 0;
    int                    rx_hold_cnt   = 0;
    logic [7:0]            rx_phase      = '0;

    bitmap_slot_allocator_top #(.MAP_WORDS(MAP_WORDS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_slot_index    (i_slot_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_byte_offset   (o_byte_offset),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic void refill_pool();
        int n;
        int base;
        n = cfg_slot_count;
        spare_held  = 1'b0;
        spare_index = '0;
        for (int w = 0; w < MAP_WORDS; w++) begin
            base = w * WORD_BITS;
            if (n >= base + WORD_BITS) begin
                free_words[w] = '1;
            end else if (n > base) begin
                free_words[w] = (32'h1 << (n - base)) - 32'h1;
            end else begin
                free_words[w] = '0;
            end
        end
    endfunction

    function automatic t_pool_answer pool_step(input logic [1:0] op,
                                               input logic [IDX_W-1:0] idx);
        t_pool_answer     ans;
        logic [RND_W-1:0] rounded;
        logic [26:0]      prod;
        int               bitpos;
        ans.status = ST_DONE;
        ans.index  = '0;
        ans.offset = '0;
        case (op)
            OP_GET: begin
                ans.status = ST_EMPTY;
                if (spare_held) begin
                    spare_held = 1'b0;
                    ans.index  = spare_index;
                    ans.status = ST_GRANTED;
                end else begin
                    for (int w = 0; w < MAP_WORDS; w++) begin
                        if (ans.status == ST_EMPTY && free_words[w] != '0) begin
                            bitpos = 0;
                            while (!free_words[w][bitpos]) begin
                                bitpos++;
                            end
                            free_words[w][bitpos] = 1'b0;
                            ans.index  = IDX_W'(w * WORD_BITS + bitpos);
                            ans.status = ST_GRANTED;
                        end
                    end
                end
                if (ans.status == ST_GRANTED) begin
                    rounded    = ({1'b0, cfg_slot_size} + 17'd3) & ~17'd3;
                    prod       = ans.index * rounded;
                    ans.offset = prod[OFS_W-1:0];
                end
            end
            OP_RETURN: begin
                if (!spare_held) begin
                    spare_held  = 1'b1;
                    spare_index = idx;
                end else begin
                    free_words[idx[IDX_W-1:BIT_W]][idx[BIT_W-1:0]] = 1'b1;
                end
            end
            OP_RECLAIM: begin
                refill_pool();
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [IDX_W-1:0] idx);
        t_pool_answer ans;
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_slot_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        ans = pool_step(op, idx);
        pending_answers.push_back(ans);
        requests_sent++;
        if (op == OP_GET && ans.status == ST_GRANTED) begin
            held_slots.push_back(ans.index);
        end
        if (op == OP_RECLAIM) begin
            held_slots.delete();
        end
    endtask

    task automatic sender_gap();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg r, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({r, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (r == REG_SLOT_COUNT) begin
            cfg_slot_count = value[IDX_W-1:0];
        end else begin
            cfg_slot_size = value[SIZE_W-1:0];
        end
        reg_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (readback !== value) begin
            $display("%0t register %0d readback: expected %0d actual %0d",
                     $time, r, value, readback);
            errors++;
        end
    endtask

    task automatic random_request();
        int               roll;
        int               pick;
        logic [IDX_W-1:0] idx;
        roll = $urandom_range(0, 99);
        idx  = IDX_W'($urandom_range(0, 1023));
        if (roll < 48) begin
            send_request(OP_GET, idx);
        end else if (roll < 90) begin
            if (roll < 86 && held_slots.size() != 0) begin
                pick = $urandom_range(0, held_slots.size() - 1);
                idx  = held_slots[pick];
                held_slots.delete(pick);
            end
            send_request(OP_RETURN, idx);
        end else if (roll < 93) begin
            send_request(OP_RECLAIM, idx);
        end else if (roll < 96) begin
            send_request(OP_UNUSED, idx);
        end else begin
            send_request(OP_GET, idx);
        end
    endtask

    task automatic test_reset_defaults();
        send_request(OP_GET, 10'd0);
        send_request(OP_GET, 10'd1023);
        send_request(OP_RETURN, 10'd1023);
        send_request(OP_RETURN, 10'd0);
        send_request(OP_GET, 10'd0);
        send_request(OP_GET, 10'd0);
        send_request(OP_UNUSED, 10'd1023);
        send_request(OP_GET, 10'd0);
    endtask

    task automatic test_config_extremes();
        wait_drain();
        write_reg(REG_SLOT_COUNT, 32'd1);
        write_reg(REG_SLOT_SIZE, 32'd0);
        send_request(OP_GET, 10'd0);
        send_request(OP_RECLAIM, 10'd0);
        send_request(OP_GET, 10'd0);
        send_request(OP_GET, 10'd0);
        send_request(OP_RETURN, 10'd0);
        send_request(OP_RETURN, 10'd1023);
        send_request(OP_GET, 10'd0);
        send_request(OP_GET, 10'd0);
        wait_drain();
        write_reg(REG_SLOT_SIZE, 32'd65535);
        write_reg(REG_SLOT_COUNT, 32'd0);
        send_request(OP_RECLAIM, 10'd0);
        send_request(OP_GET, 10'd0);
        send_request(OP_RETURN, 10'd512);
        send_request(OP_RETURN, 10'd1023);
        send_request(OP_GET, 10'd0);
        send_request(OP_GET, 10'd0);
        send_request(OP_GET, 10'd0);
    endtask

    task automatic test_traffic(input int n, input logic [IDX_W-1:0] count,
                                input logic [SIZE_W-1:0] size, input int gaps);
        wait_drain();
        write_reg(REG_SLOT_COUNT, DATA_W'(count));
        write_reg(REG_SLOT_SIZE, DATA_W'(size));
        gap_max    = gaps;
        burst_left = 0;
        send_request(OP_RECLAIM, 10'd0);
        repeat (n) begin
            sender_gap();
            random_request();
        end
    endtask

    task automatic test_output_backpressure();
        wait_drain();
        write_reg(REG_SLOT_COUNT, 32'd300);
        write_reg(REG_SLOT_SIZE, 32'd8);
        send_request(OP_RECLAIM, 10'd0);
        rx_hold_cnt <= LONG_HOLD;
        repeat (40) random_request();
        wait_drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_hold_cnt != 0) begin
            i_out_ready <= 1'b0;
            rx_hold_cnt <= rx_hold_cnt - 1;
        end else begin
            rx_phase <= rx_phase + 8'd1;
            case (rx_phase[7:6])
                2'd0:    i_out_ready <= 1'b1;
                2'd1:    i_out_ready <= ($urandom_range(0, 1) == 1);
                2'd2:    i_out_ready <= (rx_phase[1:0] == 2'd0);
                default: i_out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t unexpected result: status %0d index %0d offset %0d",
                         $time, o_status, o_granted_index, o_byte_offset);
                errors++;
            end else begin
                head_answer = pending_answers.pop_front();
                if (o_status !== head_answer.status) begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, head_answer.status, o_status);
                    errors++;
                end
                if (o_granted_index !== head_answer.index) begin
                    $display("%0t granted_index: expected %0d actual %0d",
                             $time, head_answer.index, o_granted_index);
                    errors++;
                end
                if (o_byte_offset !== head_answer.offset) begin
                    $display("%0t byte_offset: expected %0d actual %0d",
                             $time, head_answer.offset, o_byte_offset);
                    errors++;
                end
                if (head_answer.status == ST_GRANTED) begin
                    grants_seen++;
                end else if (head_answer.status == ST_EMPTY) begin
                    empties_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t no progress for %0d cycles", $time, WATCHDOG_MAX);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_op         = OP_GET;
        i_slot_index = '0;
        i_out_ready  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cfg_slot_count = 10'd1023;
        cfg_slot_size  = 16'd4;
        refill_pool();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_config_extremes();
        test_traffic(150, 10'd1023, 16'd4, 0);
        test_traffic(150, 10'd5, 16'd1, 6);
        test_traffic(150, 10'd40, 16'd65535, 3);
        test_output_backpressure();
        test_traffic(150, 10'd33, 16'd0, 8);
        test_traffic(150, 10'd64, 16'd12, 2);
        test_traffic(100, 10'd1, 16'd65533, 4);
        test_traffic(150, IDX_W'($urandom_range(1, 1023)), SIZE_W'($urandom_range(0, 65535)), 5);
        test_traffic(150, 10'd1023, 16'd65535, 1);
        wait_drain();

        $display("Run covered %0d requests across %0d register writes.",
                 requests_sent, reg_writes);
        $display("Answers seen: %0d grants, %0d empty pool, rest return/reclaim/unused.",
                 grants_seen, empties_seen);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
